// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/modinv_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular inverse package
// Controller state type for the extended Euclidean sequencer.
// ----------------------------------------------------------------------------
package modinv_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for an input transfer
        ST_CHECK,   // test divisor, launch next quotient step
        ST_DIV,     // bit-serial division in progress
        ST_DONE     // result ready to move to the output register
    } t_state;

endpackage

// ===== hw/rtl/modinv_divstep.sv =====
// ----------------------------------------------------------------------------
// Bit-serial quotient step
// Restoring division of dividend by divisor, one quotient bit per cycle,
// MSB first. Each quotient bit also folds the multiplicand into a running
// product, so quotient * multiplicand is ready with the remainder.
// ----------------------------------------------------------------------------
module modinv_divstep #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    input  logic [W-1:0] i_mult,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_prod
);

    localparam int CW = $clog2(W);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_dvd, r_dsr, r_mul, r_rem, r_acc;

    logic [W:0]    rem_sh, diff;
    logic          ge;
    logic [W-1:0]  n_rem, n_acc;

    always_comb begin
        rem_sh = {r_rem, r_dvd[W-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        ge     = (rem_sh >= {1'b0, r_dsr});
        n_rem  = ge ? diff[W-1:0] : rem_sh[W-1:0];
        // product grows MSB first: acc = 2*acc + qbit*mult
        n_acc  = {r_acc[W-2:0], 1'b0} + (ge ? r_mul : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(W - 1);
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_mul <= i_mult;
            r_rem <= '0;
            r_acc <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            r_rem <= n_rem;
            r_acc <= n_acc;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_prod = r_acc;

endmodule

// ===== hw/rtl/modular_inverse.sv =====
// ----------------------------------------------------------------------------
// Modular inverse
// Inverse of value modulo modulus by the extended Euclidean algorithm, with
// unsigned cofactors and a parity bit; returns 0 and flags no_inverse when
// the gcd is not 1.
// ----------------------------------------------------------------------------
// One item at a time. Each Euclidean quotient step is one run of the
// bit-serial restoring divider, which yields one quotient bit per cycle;
// the number of steps is at most about 1.44 * VALUE_BITS (45 for 31 bits).
// A finished result sits in an output register while the next input
// transfer is taken. Input tdata: value in the low VALUE_BITS bits,
// modulus above it. Output tdata carries the inverse and tuser the
// no_inverse flag.
module modular_inverse #(
    parameter int VALUE_BITS = 31
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // value, modulus (from bit 0 up), zero padded to bytes
    input  logic [((2*VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // inverse, zero padded to bytes
    output logic [((VALUE_BITS+7)/8)*8-1:0]        m_axis_tdata,
    // no_inverse
    output logic [0:0]                             m_axis_tuser
);

    import modinv_pkg::*;

    localparam int W     = VALUE_BITS;
    localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

    t_state         r_state, n_state;
    logic [W-1:0]   r_r_prev, r_r_cur, r_c_prev, r_c_cur, r_mod;
    logic           r_odd;
    logic [W-1:0]   r_inv;
    logic           r_no_inv, r_out_valid;

    logic           in_xfer, out_free, div_start, div_busy, div_done;
    logic           load_out;
    logic [W-1:0]   div_rem, div_prod;
    logic           n_no_inv;
    logic [W-1:0]   n_inv;

    modinv_divstep #(.W(W)) u_divstep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_r_prev),
        .i_divisor  (r_r_cur),
        .i_mult     (r_c_cur),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_prod     (div_prod)
    );

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_r_cur != '0) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // gcd sits in r_r_prev once the remainder chain ends
    always_comb begin
        n_no_inv = (r_r_prev != W'(1));
        if (n_no_inv) begin
            n_inv = '0;
        end else if (r_odd) begin
            n_inv = r_mod - r_c_prev;
        end else begin
            n_inv = r_c_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_r_prev <= s_axis_tdata[W-1:0];
            r_r_cur  <= s_axis_tdata[2*W-1:W];
            r_mod    <= s_axis_tdata[2*W-1:W];
            r_c_prev <= W'(1);
            r_c_cur  <= '0;
            r_odd    <= 1'b0;
        end else if (r_state == ST_DIV && div_done) begin
            r_r_prev <= r_r_cur;
            r_r_cur  <= div_rem;
            r_c_prev <= r_c_cur;
            r_c_cur  <= r_c_prev + div_prod;
            r_odd    <= !r_odd;
        end
        if (load_out) begin
            r_inv    <= n_inv;
            r_no_inv <= n_no_inv;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = OUT_W'(r_inv);
    assign m_axis_tuser[0] = r_no_inv;

    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_div_nonzero, r_state == ST_DIV, r_r_cur != '0,
        "division by zero remainder")
    `ASSERT_IMPLIES(a_done_in_div, div_done, r_state == ST_DIV,
        "divider finished outside a step")
    `ASSERT_IMPLIES(a_idle_quiet, r_state == ST_IDLE, !div_busy,
        "divider busy while idle")
    `ASSERT_NEXT(a_hold_result, r_state == ST_DONE && r_out_valid && !m_axis_tready,
        r_state == ST_DONE && r_out_valid, "result overwrote pending output")

endmodule
